// ===== hdl/sdis_pkg.sv =====
// ----------------------------------------------------------------------------
// sdis_pkg
// shared types, command codes and constants of the sd card init sequencer
// ----------------------------------------------------------------------------
package sdis_pkg;

  localparam int SECTOR_BYTES = 512;
  localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);

  // two-entry queues on both sides of the back part
  localparam logic [1:0] QUEUE_FULL = 2'd2;

  // configuration register indexes
  localparam logic REG_RETRY_LIMIT = 1'b0;
  localparam logic REG_RETRY_DELAY = 1'b1;

  localparam logic [7:0] RETRY_LIMIT_RST = 8'd50;
  localparam logic [7:0] RETRY_DELAY_RST = 8'd10;

  // sd command indexes
  localparam logic [5:0] IDX_GO_IDLE      = 6'd0;
  localparam logic [5:0] IDX_ALL_SEND_CID = 6'd2;
  localparam logic [5:0] IDX_SEND_RCA     = 6'd3;
  localparam logic [5:0] IDX_SELECT       = 6'd7;
  localparam logic [5:0] IDX_SEND_IF_COND = 6'd8;
  localparam logic [5:0] IDX_READ_SINGLE  = 6'd17;
  localparam logic [5:0] IDX_SEND_OP_COND = 6'd41;
  localparam logic [5:0] IDX_APP_CMD      = 6'd55;

  // response kinds
  localparam logic [1:0] RSP_NONE  = 2'd0;
  localparam logic [1:0] RSP_SHORT = 2'd1;
  localparam logic [1:0] RSP_LONG  = 2'd2;
  localparam logic [1:0] RSP_BUSY  = 2'd3;

  // status codes
  localparam logic [1:0] ST_BUSY   = 2'd0;
  localparam logic [1:0] ST_READY  = 2'd1;
  localparam logic [1:0] ST_FAILED = 2'd2;
  localparam logic [1:0] ST_REJECT = 2'd3;

  localparam logic [31:0] IF_COND_ARG   = 32'h0000_01AA;
  localparam logic [7:0]  IF_COND_ECHO  = 8'hAA;
  localparam logic [31:0] OCR_VOLTAGES  = 32'h00FF_8000;
  localparam logic [31:0] OCR_HCS       = 32'h4000_0000;
  localparam logic [7:0]  POWER_UP_MS   = 8'd50;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_DONE  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_CMD0,
    PH_CMD8,
    PH_CMD55,
    PH_ACMD41,
    PH_CMD2,
    PH_CMD3,
    PH_CMD7,
    PH_READY,
    PH_FAILED
  } phase_t;

  typedef struct packed {
    cmd_t        kind;
    logic        ok;
    logic        echo_ok;
    logic        op_ready;
    logic        op_hcs;
    logic [15:0] rca;
    logic [31:0] lba;
  } item_t;

  typedef struct packed {
    logic        issue;
    logic [5:0]  index;
    logic [31:0] argument;
    logic [1:0]  rsp_kind;
    logic        data_read;
    logic [7:0]  holdoff_ms;
    logic [1:0]  status;
    logic        high_capacity;
  } result_t;

  typedef struct packed {
    logic [7:0] retry_limit;
    logic [7:0] retry_delay;
  } cfg_t;

  function automatic logic [1:0] phase_status(phase_t ph);
    logic [1:0] st;
    st = ST_BUSY;
    if (ph == PH_READY) st = ST_READY;
    if (ph == PH_FAILED) st = ST_FAILED;
    return st;
  endfunction

endpackage

// ===== hdl/sdis_front.sv =====
// ----------------------------------------------------------------------------
// sdis_front
// accepts events, classifies them and queues them for the back part
// ----------------------------------------------------------------------------
module sdis_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  output logic            full,
  input  logic [1:0]      cmd,
  input  logic            cmd_ok,
  input  logic [31:0]     response_word,
  input  logic [31:0]     sector_number,
  output sdis_pkg::item_t item,
  output logic            item_valid,
  input  logic            item_take
);

  sdis_pkg::item_t item_in;
  sdis_pkg::item_t mem_r [2];
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic            do_push;
  logic            do_pop;

  always_comb begin
    unique case (cmd)
      2'd0:    item_in.kind = sdis_pkg::CMD_START;
      2'd1:    item_in.kind = sdis_pkg::CMD_DONE;
      2'd2:    item_in.kind = sdis_pkg::CMD_READ;
      default: item_in.kind = sdis_pkg::CMD_NONE;
    endcase
    item_in.ok       = cmd_ok;
    item_in.echo_ok  = cmd_ok && (response_word[7:0] == sdis_pkg::IF_COND_ECHO);
    item_in.op_ready = cmd_ok && response_word[31];
    item_in.op_hcs   = response_word[30];
    item_in.rca      = response_word[31:16];
    item_in.lba      = sector_number;
  end

  assign full       = (cnt_r == sdis_pkg::QUEUE_FULL);
  assign item_valid = (cnt_r != 2'd0);
  assign item       = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = item_take && item_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= item_in;
    end
  end

  a_front_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= sdis_pkg::QUEUE_FULL)
    else $error("front queue overflow");

  a_front_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    full && !item_take |=> full)
    else $error("front queue lost an entry while stalled");

endmodule

// ===== hdl/sdis_back.sv =====
// ----------------------------------------------------------------------------
// sdis_back
// card identification state machine and result queue
// ----------------------------------------------------------------------------
module sdis_back (
  input  logic              clk,
  input  logic              rst_n,
  input  sdis_pkg::cfg_t    cfg,
  input  sdis_pkg::item_t   item,
  input  logic              item_valid,
  output logic              item_take,
  output sdis_pkg::result_t result,
  output logic              empty,
  input  logic              pop
);

  sdis_pkg::phase_t  phase_r, phase_nxt;
  logic [7:0]        retry_cnt_r, retry_cnt_nxt;
  logic              block_addr_r, block_addr_nxt;
  logic [15:0]       rca_r, rca_nxt;
  logic              ready_r, ready_nxt;
  sdis_pkg::result_t res;
  logic [7:0]        retry_inc;
  logic [7:0]        limit;
  logic [31:0]       read_arg;

  sdis_pkg::result_t omem_r [2];
  logic              owr_r, ord_r;
  logic [1:0]        ocnt_r, ocnt_nxt;
  logic              do_pop;

  assign empty     = (ocnt_r == 2'd0);
  assign do_pop    = pop && !empty;
  assign item_take = item_valid && ((ocnt_r != sdis_pkg::QUEUE_FULL) || do_pop);
  assign result    = omem_r[ord_r];

  assign retry_inc = retry_cnt_r + 8'd1;
  assign limit     = (cfg.retry_limit == 8'd0) ? 8'd1 : cfg.retry_limit;
  assign read_arg  = block_addr_r ? item.lba : (item.lba << sdis_pkg::SECTOR_SHIFT);

  always_comb begin
    phase_nxt      = phase_r;
    retry_cnt_nxt  = retry_cnt_r;
    block_addr_nxt = block_addr_r;
    rca_nxt        = rca_r;
    ready_nxt      = ready_r;
    res            = '0;
    unique case (item.kind)
      sdis_pkg::CMD_START: begin
        block_addr_nxt = 1'b1;
        rca_nxt        = 16'd0;
        ready_nxt      = 1'b0;
        retry_cnt_nxt  = 8'd0;
        phase_nxt      = sdis_pkg::PH_CMD0;
        res.issue      = 1'b1;
        res.index      = sdis_pkg::IDX_GO_IDLE;
        res.rsp_kind   = sdis_pkg::RSP_NONE;
      end
      sdis_pkg::CMD_DONE: begin
        unique case (phase_r) inside
          sdis_pkg::PH_CMD0: begin
            phase_nxt      = sdis_pkg::PH_CMD8;
            res.issue      = 1'b1;
            res.index      = sdis_pkg::IDX_SEND_IF_COND;
            res.argument   = sdis_pkg::IF_COND_ARG;
            res.rsp_kind   = sdis_pkg::RSP_SHORT;
            res.holdoff_ms = sdis_pkg::POWER_UP_MS;
          end
          sdis_pkg::PH_CMD8: begin
            block_addr_nxt = item.echo_ok;
            retry_cnt_nxt  = 8'd0;
            phase_nxt      = sdis_pkg::PH_CMD55;
            res.issue      = 1'b1;
            res.index      = sdis_pkg::IDX_APP_CMD;
            res.rsp_kind   = sdis_pkg::RSP_SHORT;
          end
          sdis_pkg::PH_CMD55, sdis_pkg::PH_ACMD41: begin
            if (phase_r == sdis_pkg::PH_CMD55 && item.ok) begin
              phase_nxt    = sdis_pkg::PH_ACMD41;
              res.issue    = 1'b1;
              res.index    = sdis_pkg::IDX_SEND_OP_COND;
              res.argument = sdis_pkg::OCR_VOLTAGES |
                             (block_addr_r ? sdis_pkg::OCR_HCS : 32'd0);
              res.rsp_kind = sdis_pkg::RSP_SHORT;
            end else if (phase_r == sdis_pkg::PH_ACMD41 && item.op_ready) begin
              block_addr_nxt = item.op_hcs;
              phase_nxt      = sdis_pkg::PH_CMD2;
              res.issue      = 1'b1;
              res.index      = sdis_pkg::IDX_ALL_SEND_CID;
              res.rsp_kind   = sdis_pkg::RSP_LONG;
            end else begin
              // failed attempt, retry or move on once the limit is hit
              retry_cnt_nxt  = retry_inc;
              res.issue      = 1'b1;
              res.holdoff_ms = cfg.retry_delay;
              if (retry_inc >= limit) begin
                phase_nxt    = sdis_pkg::PH_CMD2;
                res.index    = sdis_pkg::IDX_ALL_SEND_CID;
                res.rsp_kind = sdis_pkg::RSP_LONG;
              end else begin
                phase_nxt    = sdis_pkg::PH_CMD55;
                res.index    = sdis_pkg::IDX_APP_CMD;
                res.rsp_kind = sdis_pkg::RSP_SHORT;
              end
            end
          end
          sdis_pkg::PH_CMD2: begin
            if (item.ok) begin
              phase_nxt    = sdis_pkg::PH_CMD3;
              res.issue    = 1'b1;
              res.index    = sdis_pkg::IDX_SEND_RCA;
              res.rsp_kind = sdis_pkg::RSP_SHORT;
            end else begin
              phase_nxt = sdis_pkg::PH_FAILED;
            end
          end
          sdis_pkg::PH_CMD3: begin
            if (item.ok) begin
              rca_nxt      = item.rca;
              phase_nxt    = sdis_pkg::PH_CMD7;
              res.issue    = 1'b1;
              res.index    = sdis_pkg::IDX_SELECT;
              res.argument = {item.rca, 16'd0};
              res.rsp_kind = sdis_pkg::RSP_BUSY;
            end else begin
              phase_nxt = sdis_pkg::PH_FAILED;
            end
          end
          sdis_pkg::PH_CMD7: begin
            if (item.ok) begin
              ready_nxt = 1'b1;
              phase_nxt = sdis_pkg::PH_READY;
            end else begin
              phase_nxt = sdis_pkg::PH_FAILED;
            end
          end
          default: begin
          end
        endcase
      end
      sdis_pkg::CMD_READ: begin
        if (ready_r && phase_r == sdis_pkg::PH_READY) begin
          res.issue     = 1'b1;
          res.index     = sdis_pkg::IDX_READ_SINGLE;
          res.argument  = read_arg;
          res.rsp_kind  = sdis_pkg::RSP_SHORT;
          res.data_read = 1'b1;
        end
      end
      default: begin
      end
    endcase
    unique case (item.kind)
      sdis_pkg::CMD_START: res.status = sdis_pkg::ST_BUSY;
      sdis_pkg::CMD_READ:  res.status = (ready_r && phase_r == sdis_pkg::PH_READY) ?
                                        sdis_pkg::ST_READY : sdis_pkg::ST_REJECT;
      default:             res.status = sdis_pkg::phase_status(phase_nxt);
    endcase
    res.high_capacity = block_addr_nxt;
  end

  assign ocnt_nxt = ocnt_r + {1'b0, item_take} - {1'b0, do_pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= sdis_pkg::PH_IDLE;
      retry_cnt_r  <= 8'd0;
      block_addr_r <= 1'b1;
      rca_r        <= 16'd0;
      ready_r      <= 1'b0;
      owr_r        <= 1'b0;
      ord_r        <= 1'b0;
      ocnt_r       <= 2'd0;
    end else begin
      if (item_take) begin
        phase_r      <= phase_nxt;
        retry_cnt_r  <= retry_cnt_nxt;
        block_addr_r <= block_addr_nxt;
        rca_r        <= rca_nxt;
        ready_r      <= ready_nxt;
        owr_r        <= ~owr_r;
      end
      if (do_pop) begin
        ord_r <= ~ord_r;
      end
      ocnt_r <= ocnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      omem_r[owr_r] <= res;
    end
  end

  a_out_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ocnt_r <= sdis_pkg::QUEUE_FULL)
    else $error("result queue overflow");

  a_start_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    item_take && item.kind == sdis_pkg::CMD_START
    |=> phase_r == sdis_pkg::PH_CMD0 && retry_cnt_r == 8'd0 && rca_r == 16'd0)
    else $error("start did not restart the sequence");

  a_ready_phase: assert property (@(posedge clk) disable iff (!rst_n)
    ready_r == (phase_r == sdis_pkg::PH_READY))
    else $error("ready flag out of step with phase");

endmodule

// ===== hdl/sd_card_init_sequencer.sv =====
// ----------------------------------------------------------------------------
// sd_card_init_sequencer
// sd card identification sequencer with single-block read command generation
// a result is written into the registered result queue when its item is taken;
// throughput: one item per cycle unless a queue stalls, set by the state update in the back
// part; two-entry queues before and after it absorb stalls on either side
// reset: synchronous active-low rst_n clears both queues and the phase to idle
// and loads retry_limit 50 and the retry delay 10
// ----------------------------------------------------------------------------
module sd_card_init_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_cmd,
  input  logic        in_cmd_ok,
  input  logic [31:0] in_response_word,
  input  logic [31:0] in_sector_number,
  output logic        empty,
  input  logic        pop,
  output logic        out_issue,
  output logic [5:0]  out_command_index,
  output logic [31:0] out_argument,
  output logic [1:0]  out_response_kind,
  output logic        out_data_read,
  output logic [7:0]  out_delay_before_ms,
  output logic [1:0]  out_status,
  output logic        out_high_capacity,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  sdis_pkg::cfg_t    cfg_r, cfg_nxt;
  sdis_pkg::item_t   item;
  sdis_pkg::result_t result;
  logic              item_valid;
  logic              item_take;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (paddr[2])
        sdis_pkg::REG_RETRY_LIMIT: cfg_nxt.retry_limit = pwdata[7:0];
        sdis_pkg::REG_RETRY_DELAY: cfg_nxt.retry_delay = pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      sdis_pkg::REG_RETRY_LIMIT: prdata = {24'd0, cfg_r.retry_limit};
      sdis_pkg::REG_RETRY_DELAY: prdata = {24'd0, cfg_r.retry_delay};
      default:                   prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.retry_limit <= sdis_pkg::RETRY_LIMIT_RST;
      cfg_r.retry_delay <= sdis_pkg::RETRY_DELAY_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  sdis_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .cmd           (in_cmd),
    .cmd_ok        (in_cmd_ok),
    .response_word (in_response_word),
    .sector_number (in_sector_number),
    .item          (item),
    .item_valid    (item_valid),
    .item_take     (item_take)
  );

  sdis_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item       (item),
    .item_valid (item_valid),
    .item_take  (item_take),
    .result     (result),
    .empty      (empty),
    .pop        (pop)
  );

  assign out_issue           = result.issue;
  assign out_command_index   = result.index;
  assign out_argument        = result.argument;
  assign out_response_kind   = result.rsp_kind;
  assign out_data_read       = result.data_read;
  assign out_delay_before_ms = result.holdoff_ms;
  assign out_status          = result.status;
  assign out_high_capacity   = result.high_capacity;

endmodule

// ===== tb/sv/sdis_scoreboard_pkg.sv =====
// ----------------------------------------------------------------------------
// sdis_scoreboard_pkg
// tracks the card bring-up sequence on every accepted event, queues the
// command word the sequencer should answer with and checks each popped word
// ----------------------------------------------------------------------------
package sdis_scoreboard_pkg;

  import sdis_pkg::*;

  class sdis_scoreboard;

    logic [7:0]  retry_limit;
    logic [7:0]  retry_delay;
    phase_t      ph;
    logic [7:0]  tries;
    logic        block_addr;
    logic [15:0] rca;
    logic        card_ready;
    result_t     next_cmds[$];
    int          n_checked;
    int          n_errors;
    int          n_ready;
    int          n_failed;

    function new();
      retry_limit = RETRY_LIMIT_RST;
      retry_delay = RETRY_DELAY_RST;
      ph          = PH_IDLE;
      tries       = '0;
      block_addr  = 1'b1;
      rca         = '0;
      card_ready  = 1'b0;
      n_checked   = 0;
      n_errors    = 0;
      n_ready     = 0;
      n_failed    = 0;
    endfunction

    function void set_reg(logic idx, logic [7:0] val);
      if (idx == REG_RETRY_LIMIT) retry_limit = val;
      else retry_delay = val;
    endfunction

    function bit in_bringup();
      return ph != PH_IDLE && ph != PH_READY && ph != PH_FAILED;
    endfunction

    function logic [1:0] phase_code();
      if (ph == PH_READY) return ST_READY;
      if (ph == PH_FAILED) return ST_FAILED;
      return ST_BUSY;
    endfunction

    function result_t cmd_word(logic [5:0] idx, logic [31:0] arg, logic [1:0] kind,
                               logic data, logic [7:0] delay);
      result_t r;
      r            = '0;
      r.issue      = 1'b1;
      r.index      = idx;
      r.argument   = arg;
      r.rsp_kind   = kind;
      r.data_read  = data;
      r.holdoff_ms = delay;
      return r;
    endfunction

    // a failed CMD55 or ACMD41 attempt: retry or give up and go on to CMD2
    function result_t retry_or_move_on();
      logic [7:0] lim;
      lim   = (retry_limit == 8'd0) ? 8'd1 : retry_limit;
      tries = tries + 8'd1;
      if (tries >= lim) begin
        ph = PH_CMD2;
        return cmd_word(IDX_ALL_SEND_CID, '0, RSP_LONG, 1'b0, retry_delay);
      end
      ph = PH_CMD55;
      return cmd_word(IDX_APP_CMD, '0, RSP_SHORT, 1'b0, retry_delay);
    endfunction

    function void give_up();
      ph = PH_FAILED;
      n_failed++;
    endfunction

    function void note_item(cmd_t c, logic ok, logic [31:0] resp, logic [31:0] lba);
      result_t    r;
      logic [31:0] addr;
      r = '0;
      case (c)
        CMD_START: begin
          block_addr = 1'b1;
          rca        = '0;
          card_ready = 1'b0;
          tries      = '0;
          ph         = PH_CMD0;
          r = cmd_word(IDX_GO_IDLE, '0, RSP_NONE, 1'b0, 8'd0);
          r.status = ST_BUSY;
        end
        CMD_DONE: begin
          case (ph)
            PH_CMD0: begin
              ph = PH_CMD8;
              r = cmd_word(IDX_SEND_IF_COND, IF_COND_ARG, RSP_SHORT, 1'b0, POWER_UP_MS);
            end
            PH_CMD8: begin
              block_addr = ok && (resp[7:0] == IF_COND_ECHO);
              tries      = '0;
              ph         = PH_CMD55;
              r = cmd_word(IDX_APP_CMD, '0, RSP_SHORT, 1'b0, 8'd0);
            end
            PH_CMD55: begin
              if (ok) begin
                ph = PH_ACMD41;
                r = cmd_word(IDX_SEND_OP_COND, OCR_VOLTAGES | (block_addr ? OCR_HCS : '0),
                             RSP_SHORT, 1'b0, 8'd0);
              end else begin
                r = retry_or_move_on();
              end
            end
            PH_ACMD41: begin
              if (ok && resp[31]) begin
                block_addr = resp[30];
                ph         = PH_CMD2;
                r = cmd_word(IDX_ALL_SEND_CID, '0, RSP_LONG, 1'b0, 8'd0);
              end else begin
                r = retry_or_move_on();
              end
            end
            PH_CMD2: begin
              if (ok) begin
                ph = PH_CMD3;
                r = cmd_word(IDX_SEND_RCA, '0, RSP_SHORT, 1'b0, 8'd0);
              end else begin
                give_up();
              end
            end
            PH_CMD3: begin
              if (ok) begin
                rca = resp[31:16];
                ph  = PH_CMD7;
                r = cmd_word(IDX_SELECT, {rca, 16'h0000}, RSP_BUSY, 1'b0, 8'd0);
              end else begin
                give_up();
              end
            end
            PH_CMD7: begin
              if (ok) begin
                card_ready = 1'b1;
                ph         = PH_READY;
                n_ready++;
              end else begin
                give_up();
              end
            end
            default: begin
            end
          endcase
          r.status = phase_code();
        end
        CMD_READ: begin
          if (card_ready && ph == PH_READY) begin
            addr = block_addr ? lba : lba * SECTOR_BYTES;
            r = cmd_word(IDX_READ_SINGLE, addr, RSP_SHORT, 1'b1, 8'd0);
            r.status = ST_READY;
          end else begin
            r.status = ST_REJECT;
          end
        end
        default: r.status = phase_code();
      endcase
      r.high_capacity = block_addr;
      next_cmds.push_back(r);
    endfunction

    function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t mismatch %s: expected 0x%0h, actual 0x%0h", $time, name, want, got);
        n_errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (next_cmds.size() == 0) begin
        $display("%0t unexpected transfer: expected nothing, actual 0x%0h", $time, got);
        n_errors++;
        return;
      end
      want = next_cmds.pop_front();
      n_checked++;
      cmp_field("issue", want.issue, got.issue);
      cmp_field("command_index", want.index, got.index);
      cmp_field("argument", want.argument, got.argument);
      cmp_field("response_kind", want.rsp_kind, got.rsp_kind);
      cmp_field("data_read", want.data_read, got.data_read);
      cmp_field("delay_before_ms", want.holdoff_ms, got.holdoff_ms);
      cmp_field("status", want.status, got.status);
      cmp_field("high_capacity", want.high_capacity, got.high_capacity);
    endfunction

  endclass

endpackage

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// sd card init sequencer: directed bring-ups to ready and to a CMD2 failure, then
// random bring-up sessions with mostly well-formed completions, stray and
// restart events and sector reads, under several retry settings and random
// stalls on both queue sides; every popped command word is checked
// ----------------------------------------------------------------------------
module tb;

  import sdis_pkg::*;
  import sdis_scoreboard_pkg::*;

  localparam int PHASE_ITEMS = 170;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  in_cmd = '0;
  logic        in_cmd_ok = 1'b0;
  logic [31:0] in_response_word = '0;
  logic [31:0] in_sector_number = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic        out_issue;
  logic [5:0]  out_command_index;
  logic [31:0] out_argument;
  logic [1:0]  out_response_kind;
  logic        out_data_read;
  logic [7:0]  out_delay_before_ms;
  logic [1:0]  out_status;
  logic        out_high_capacity;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  result_t        got_cmd;
  sdis_scoreboard sb;
  bit             calm = 1'b0;
  int             n_items = 0;
  int             n_settings = 0;

  always #6 clk = ~clk;

  sd_card_init_sequencer u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .push                (push),
    .full                (full),
    .in_cmd              (in_cmd),
    .in_cmd_ok           (in_cmd_ok),
    .in_response_word    (in_response_word),
    .in_sector_number    (in_sector_number),
    .empty               (empty),
    .pop                 (pop),
    .out_issue           (out_issue),
    .out_command_index   (out_command_index),
    .out_argument        (out_argument),
    .out_response_kind   (out_response_kind),
    .out_data_read       (out_data_read),
    .out_delay_before_ms (out_delay_before_ms),
    .out_status          (out_status),
    .out_high_capacity   (out_high_capacity),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  assign got_cmd = {out_issue, out_command_index, out_argument, out_response_kind,
                    out_data_read, out_delay_before_ms, out_status, out_high_capacity};

  // result side
  always @(posedge clk) begin
    if (rst_n && pop && !empty) sb.check_result(got_cmd);
    pop <= calm || ($urandom_range(99) >= 12);
  end

  task automatic push_event(cmd_t c, logic ok, logic [31:0] resp, logic [31:0] lba);
    while (!calm && $urandom_range(99) < 12) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push             <= 1'b1;
    in_cmd           <= c;
    in_cmd_ok        <= ok;
    in_response_word <= resp;
    in_sector_number <= lba;
    do @(posedge clk); while (full);
    sb.note_item(c, ok, resp, lba);
    n_items++;
  endtask

  task automatic drain();
    push <= 1'b0;
    while (sb.next_cmds.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic idx, logic [7:0] val);
    logic [2:0] addr;
    addr = {idx, 2'b00};
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {24'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, val);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {24'd0, val}) begin
      $display("%0t mismatch register %0d readback: expected 0x%0h, actual 0x%0h",
               $time, idx, {24'd0, val}, prdata);
      sb.n_errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(logic [7:0] lim, logic [7:0] dly);
    drain();
    cfg_write(REG_RETRY_LIMIT, lim);
    cfg_write(REG_RETRY_DELAY, dly);
    n_settings++;
  endtask

  function automatic logic [31:0] pick_lba();
    case ($urandom_range(7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_noise();
    push_event(cmd_t'($urandom_range(3)), 1'($urandom_range(1)), $urandom, pick_lba());
  endtask

  // completion shaped to the command the card was just sent
  task automatic push_completion();
    logic [31:0] resp;
    logic        ok;
    ok   = ($urandom_range(9) != 0);
    resp = $urandom;
    if (sb.ph == PH_CMD8 && $urandom_range(3) != 0) resp[7:0] = IF_COND_ECHO;
    if (sb.ph == PH_ACMD41) resp[31] = ($urandom_range(1) == 1);
    push_event(CMD_DONE, ok, resp, $urandom);
  endtask

  task automatic run_session(int stop_at);
    int n_reads;
    push_event(CMD_START, 1'($urandom_range(1)), $urandom, $urandom);
    while (sb.in_bringup() && n_items < stop_at) begin
      if ($urandom_range(99) < 5) push_noise();
      else push_completion();
    end
    n_reads = $urandom_range(6);
    repeat (n_reads) begin
      if ($urandom_range(9) == 0) push_noise();
      else push_event(CMD_READ, 1'($urandom_range(1)), $urandom, pick_lba());
    end
  endtask

  task automatic random_phase(logic [7:0] lim, logic [7:0] dly);
    int stop_at;
    configure(lim, dly);
    stop_at = n_items + PHASE_ITEMS;
    while (n_items < stop_at) run_session(stop_at);
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: stray events at idle, then a high capacity bring-up with retries
    push_event(CMD_NONE, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_event(CMD_DONE, 1'b1, 32'h0000_0000, 32'h0000_0000);
    push_event(CMD_READ, 1'b0, 32'h0000_0000, 32'h1234_5678);
    push_event(CMD_START, 1'b0, 32'h0000_0000, 32'h0000_0000);
    push_event(CMD_DONE, 1'b0, 32'h0000_0000, 32'h0000_0000);
    push_event(CMD_DONE, 1'b1, IF_COND_ARG, 32'h0000_0000);
    push_event(CMD_DONE, 1'b0, 32'hFFFF_FFFF, 32'h0000_0000);
    push_event(CMD_DONE, 1'b1, 32'h0000_0000, 32'h0000_0000);
    push_event(CMD_DONE, 1'b1, 32'h7FFF_FFFF, 32'h0000_0000);
    push_event(CMD_DONE, 1'b1, 32'h0000_0000, 32'h0000_0000);
    push_event(CMD_DONE, 1'b1, 32'hC0FF_8000, 32'h0000_0000);
    push_event(CMD_DONE, 1'b1, 32'h0000_0000, 32'h0000_0000);
    push_event(CMD_DONE, 1'b1, 32'hFFFF_0000, 32'h0000_0000);
    push_event(CMD_DONE, 1'b1, 32'h0000_0000, 32'h0000_0000);
    push_event(CMD_READ, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF);
    push_event(CMD_READ, 1'b0, 32'hFFFF_FFFF, 32'h0000_0000);
    push_event(CMD_DONE, 1'b1, 32'hFFFF_FFFF, 32'h0000_0000);
    push_event(CMD_NONE, 1'b0, 32'h0000_0000, 32'h0000_0000);
    // restart from ready, byte addressed card that then fails on CMD2
    push_event(CMD_START, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_event(CMD_DONE, 1'b1, 32'h0000_0000, 32'h0000_0000);
    push_event(CMD_DONE, 1'b0, IF_COND_ARG, 32'h0000_0000);
    push_event(CMD_DONE, 1'b1, 32'h0000_0000, 32'h0000_0000);
    push_event(CMD_DONE, 1'b1, 32'h8000_0000, 32'h0000_0000);
    push_event(CMD_DONE, 1'b0, 32'h0000_0000, 32'h0000_0000);
    push_event(CMD_READ, 1'b1, 32'h0000_0000, 32'h0000_0001);
    push_event(CMD_DONE, 1'b1, 32'h0000_0000, 32'h0000_0000);

    random_phase(8'd1, 8'd0);
    random_phase(8'd0, 8'($urandom_range(255)));
    random_phase(8'd255, 8'd255);
    calm = 1'b1;
    random_phase(8'd2, 8'($urandom_range(255)));
    calm = 1'b0;
    random_phase(8'($urandom_range(1, 8)), 8'($urandom_range(255)));
    random_phase(8'($urandom_range(255)), 8'($urandom_range(255)));

    drain();
    repeat (8) @(posedge clk);
    $display("covered %0d events and %0d command words under %0d retry settings",
             n_items, sb.n_checked, n_settings + 1);
    $display("bring-ups ending ready: %0d, ending failed: %0d", sb.n_ready, sb.n_failed);
    if (sb.n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d command words outstanding", sb.next_cmds.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
